FILE: hdl/anchored_substring_matcher_top_assert.svh
// Assertion macros for the anchored substring matcher top level.
`ifndef ANCHORED_SUBSTRING_MATCHER_TOP_ASSERT_SVH
`define ANCHORED_SUBSTRING_MATCHER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ASM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ASM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/asm_pkg.sv
// Shared types and constants for the anchored substring matcher.
package asm_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int RQ_DEPTH_DEF    = 4;

	localparam logic [4:0] COUNT_SAT = 5'd31;

	// anchor codes; code 3 behaves as unanchored
	localparam logic [1:0] ANCHOR_NONE  = 2'd0;
	localparam logic [1:0] ANCHOR_START = 2'd1;
	localparam logic [1:0] ANCHOR_END   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_CHARS_LOW  = 2'd0;
	localparam logic [1:0] REG_CHARS_HIGH = 2'd1;
	localparam logic [1:0] REG_LENGTH     = 2'd2;
	localparam logic [1:0] REG_ANCHOR     = 2'd3;

	typedef struct packed {
		logic [127:0] chars;
		logic [4:0]   len;
		logic [1:0]   mode;
	} asm_cfg_t;

	typedef struct packed {
		logic push;
		logic match;
	} asm_res_t;

endpackage

FILE: hdl/asm_match.sv
// Front end: byte window, parallel pattern compare and per-text verdict.
module asm_match #(
	parameter int PATTERN_MAX = asm_pkg::PATTERN_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  asm_pkg::asm_cfg_t cfg,
	input  logic             accept,
	input  logic [7:0]       text_char,
	input  logic             last_char,
	output asm_pkg::asm_res_t res
);
	import asm_pkg::*;

	localparam logic [4:0] PM_W = 5'(PATTERN_MAX);

	logic [7:0] window_q [PATTERN_MAX];
	logic [7:0] win_n [PATTERN_MAX];
	logic [7:0] pat [16];
	logic [4:0] seen_q, seen_n, len_eff;
	logic       found_q, found_n, tail, hit, verdict;
	logic [PATTERN_MAX-1:0] ok;

	always_comb begin
		win_n[0] = text_char;
		for (int i = 1; i < PATTERN_MAX; i++) begin
			win_n[i] = window_q[i-1];
		end
		for (int k = 0; k < 16; k++) begin
			pat[k] = cfg.chars[8*k +: 8];
		end
		seen_n  = (seen_q == COUNT_SAT) ? seen_q : seen_q + 5'd1;
		len_eff = (cfg.len > PM_W) ? PM_W : cfg.len;
	end

	// position j of the window lines up with pattern byte len-1-j
	always_comb begin
		logic [4:0] pidx;
		pidx = '0;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			pidx  = len_eff - 5'(j) - 5'd1;
			ok[j] = (5'(j) >= len_eff) || (win_n[j] == pat[pidx[3:0]]);
		end
		tail = (seen_n >= len_eff) && (&ok);
	end

	always_comb begin
		case (cfg.mode)
			ANCHOR_START: hit = (seen_n == len_eff) && tail;
			ANCHOR_END:   hit = 1'b0;
			default:      hit = tail;
		endcase
		found_n = found_q | hit;
		if (len_eff == 5'd0) begin
			verdict = 1'b1;
		end else if (cfg.mode == ANCHOR_END) begin
			verdict = tail;
		end else begin
			verdict = found_n;
		end
		res.push  = accept && last_char;
		res.match = verdict;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				window_q[i] <= win_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			found_q <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				seen_q  <= '0;
				found_q <= 1'b0;
			end else begin
				seen_q  <= seen_n;
				found_q <= found_n;
			end
		end
	end

endmodule

FILE: hdl/asm_rq.sv
// Back end: result queue presenting the oldest verdict word.
module asm_rq #(
	parameter int DEPTH = asm_pkg::RQ_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  asm_pkg::asm_res_t res,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output logic              match_found
);
	import asm_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full        = (count_q == FULL_CNT);
	assign empty       = (count_q == '0);
	assign match_found = mem_q[rd_ptr_q];
	assign do_push     = res.push && !full;
	assign do_pop      = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= res.match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: hdl/anchored_substring_matcher_top.sv
// Top level: config registers, matcher front end and result queue.
// Throughput: one text byte per cycle, every cycle, while the result queue has room.
// Latency: a verdict is queued at its last byte's edge, shown next cycle behind older words.
// The byte compare is one window shift plus a parallel compare of all positions.
// arst_n clears byte count, found flag, queue pointers and all config registers.
// The byte window itself is not reset; only bytes of the current text are compared.
`include "anchored_substring_matcher_top_assert.svh"

module anchored_substring_matcher_top #(
	parameter int PATTERN_MAX = asm_pkg::PATTERN_MAX_DEF,
	parameter int RQ_DEPTH    = asm_pkg::RQ_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_char,
	input  logic        last_char,
	// verdict words out
	output logic        empty,
	input  logic        pop,
	output logic        match_found,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import asm_pkg::*;

	logic [63:0] chars_low_q, chars_high_q;
	logic [4:0]  length_q;
	logic [1:0]  anchor_q;
	asm_cfg_t    cfg;
	asm_res_t    res;
	logic        accept;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_low_q  <= '0;
			chars_high_q <= '0;
			length_q     <= '0;
			anchor_q     <= ANCHOR_NONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CHARS_LOW:  chars_low_q  <= cfg_data;
				REG_CHARS_HIGH: chars_high_q <= cfg_data;
				REG_LENGTH:     length_q     <= cfg_data[4:0];
				REG_ANCHOR:     anchor_q     <= cfg_data[1:0];
				default:        ;
			endcase
		end
	end

	assign cfg.chars = {chars_high_q, chars_low_q};
	assign cfg.len   = length_q;
	assign cfg.mode  = anchor_q;

	// a byte is taken whenever the queue can hold a verdict; non-last bytes
	// could pass even when full, but a single rule keeps the stall simple
	assign accept = push && !full;

	asm_match #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.text_char (text_char),
		.last_char (last_char),
		.res       (res)
	);

	asm_rq #(
		.DEPTH(RQ_DEPTH)
	) u_rq (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.pop         (pop),
		.full        (full),
		.empty       (empty),
		.match_found (match_found)
	);

	// a last byte taken always leaves a verdict waiting next cycle
	`ASM_ASSERT_NEXT(a_last_gives_word, accept && last_char, !empty, "verdict word lost")
	// nothing shows up in an empty queue without a last byte
	`ASM_ASSERT_NEXT(a_no_spurious_word, empty && !(accept && last_char), empty,
		"spurious verdict word")
	// a full queue has words to offer
	`ASM_ASSERT_NOW(a_full_not_empty, full, !empty, "queue full and empty at once")

endmodule
